// ===== src/assert_macros.svh =====
// assert_macros.svh: shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ATG_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// condition never seen outside reset
`define ATG_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ===== src/atg_pkg.sv =====
// ----------------------------------------------------------------------------
// atg_pkg
// Types, constants and the arctangent table for the tilt and gyro rate block.
// ----------------------------------------------------------------------------
`default_nettype none

package atg_pkg;

    localparam int CW        = 32;
    localparam int FRAC_BITS = 12;

    typedef logic signed [CW-1:0] t_cword;
    typedef logic signed [63:0]   t_prod;

    localparam t_cword INV_GAIN_Q30 = 32'sd652032874;
    localparam logic [26:0] RECIP_10K = 27'd109951162;
    localparam logic [24:0] RECIP_131 = 25'd32786009;
    localparam logic [27:0] HALF_10K  = 28'd5000;
    localparam logic [27:0] DIV_10K   = 28'd10000;
    localparam logic [22:0] DIV_131   = 23'd131;
    localparam logic [14:0] ANGLE_MAX = 15'd9000;

    typedef struct packed {
        logic        neg;
        logic [22:0] t;
    } t_grate;

    typedef struct packed {
        logic signed [15:0] num;
        logic signed [15:0] gx;
        logic signed [15:0] gy;
        logic signed [15:0] gz;
    } t_mside;

    typedef struct packed {
        logic   zero;
        t_grate gx;
        t_grate gy;
        t_grate gz;
    } t_aside;

    typedef struct packed {
        logic        neg;
        logic [27:0] t;
        logic [54:0] prod;
    } t_cent;

    typedef struct packed {
        logic        neg;
        logic [22:0] t;
        logic [47:0] prod;
    } t_gdiv;

    // atan(2^-i) in micro-degrees
    function automatic t_cword atan_udeg(input logic [4:0] idx);
        t_cword v;
        case (idx)
            5'd0:    v = 32'sd45000000;
            5'd1:    v = 32'sd26565051;
            5'd2:    v = 32'sd14036243;
            5'd3:    v = 32'sd7125016;
            5'd4:    v = 32'sd3576334;
            5'd5:    v = 32'sd1789911;
            5'd6:    v = 32'sd895174;
            5'd7:    v = 32'sd447614;
            5'd8:    v = 32'sd223811;
            5'd9:    v = 32'sd111906;
            5'd10:   v = 32'sd55953;
            5'd11:   v = 32'sd27976;
            5'd12:   v = 32'sd13988;
            5'd13:   v = 32'sd6994;
            5'd14:   v = 32'sd3497;
            5'd15:   v = 32'sd1749;
            5'd16:   v = 32'sd874;
            5'd17:   v = 32'sd437;
            5'd18:   v = 32'sd219;
            5'd19:   v = 32'sd109;
            5'd20:   v = 32'sd55;
            5'd21:   v = 32'sd27;
            5'd22:   v = 32'sd14;
            5'd23:   v = 32'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== src/atg_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// atg_cordic_stage
// One registered CORDIC vectoring iteration with a side payload carried along.
// ----------------------------------------------------------------------------
`default_nettype none

module atg_cordic_stage #(
    parameter int SHIFT  = 0,
    parameter int SIDE_W = 1
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  atg_pkg::t_cword      i_x,
    input  atg_pkg::t_cword      i_y,
    input  atg_pkg::t_cword      i_z,
    input  wire [SIDE_W-1:0]     i_side,
    output logic                 o_valid,
    output atg_pkg::t_cword      o_x,
    output atg_pkg::t_cword      o_y,
    output atg_pkg::t_cword      o_z,
    output logic [SIDE_W-1:0]    o_side
);

    localparam atg_pkg::t_cword ATAN = atg_pkg::atan_udeg(5'(SHIFT));

    logic            r_valid;
    atg_pkg::t_cword r_x, r_y, r_z;
    logic [SIDE_W-1:0] r_side;
    atg_pkg::t_cword n_x, n_y, n_z;

    always_comb begin
        if (!i_y[atg_pkg::CW-1]) begin
            n_x = i_x + (i_y >>> SHIFT);
            n_y = i_y - (i_x >>> SHIFT);
            n_z = i_z + ATAN;
        end else begin
            n_x = i_x - (i_y >>> SHIFT);
            n_y = i_y + (i_x >>> SHIFT);
            n_z = i_z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// ===== src/accel_tilt_and_gyro_rate_top.sv =====
// Throughput: one sample per cycle; busy is held low, every stage advances each cycle.
// An input capture register, two chained CORDIC pipelines (magnitude, then angle), one
// gain multiply stage and two rounding-divide stages set the depth.
// Reset (synchronous, active low) clears the valid bits only; no result is lost
// or made up after reset. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
// accel_tilt_and_gyro_rate_top
// Roll and pitch from accelerometer data by CORDIC vectoring, gyro rates scaled
// to centidegrees per second.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module accel_tilt_and_gyro_rate_top #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    input  wire signed [15:0]  i_accel_x,
    input  wire signed [15:0]  i_accel_y,
    input  wire signed [15:0]  i_accel_z,
    input  wire signed [15:0]  i_gyro_x,
    input  wire signed [15:0]  i_gyro_y,
    input  wire signed [15:0]  i_gyro_z,
    output logic               busy,
    output logic               o_done,
    output logic signed [14:0] o_roll_centideg,
    output logic signed [14:0] o_pitch_centideg,
    output logic signed [16:0] o_rate_x_cdps,
    output logic signed [16:0] o_rate_y_cdps,
    output logic signed [16:0] o_rate_z_cdps
);

    localparam int N   = CORDIC_STAGES;
    localparam int LAT = 2 * CORDIC_STAGES + 4;

    function automatic logic [16:0] abs16(input logic signed [15:0] v);
        return v[15] ? ({1'b0, ~v} + 17'd1) : {1'b0, v};
    endfunction

    function automatic atg_pkg::t_cword to_q12(input logic [16:0] v);
        return atg_pkg::t_cword'({v, {atg_pkg::FRAC_BITS{1'b0}}});
    endfunction

    function automatic atg_pkg::t_grate gyro_pre(input logic signed [15:0] v);
        atg_pkg::t_grate g;
        g.neg = v[15];
        g.t   = 23'(abs16(v)) * 23'd200 + 23'd65;
        return g;
    endfunction

    function automatic atg_pkg::t_gdiv gyro_mul(input atg_pkg::t_grate g);
        atg_pkg::t_gdiv d;
        d.neg  = g.neg;
        d.t    = g.t;
        d.prod = 48'(g.t) * 48'(atg_pkg::RECIP_131);
        return d;
    endfunction

    function automatic logic signed [16:0] gyro_fin(input atg_pkg::t_gdiv d);
        logic [15:0] q0;
        logic [22:0] r;
        logic [16:0] q;
        q0 = d.prod[47:32];
        r  = d.t - 23'(q0) * atg_pkg::DIV_131;
        q  = (r >= atg_pkg::DIV_131) ? (17'(q0) + 17'd1) : 17'(q0);
        return d.neg ? -$signed(q) : $signed(q);
    endfunction

    function automatic atg_pkg::t_cent cent_mul(input atg_pkg::t_cword z);
        atg_pkg::t_cent c;
        c.neg  = z[atg_pkg::CW-1];
        c.t    = (c.neg ? 28'(-z) : 28'(z)) + atg_pkg::HALF_10K;
        c.prod = 55'(c.t) * 55'(atg_pkg::RECIP_10K);
        return c;
    endfunction

    function automatic logic [14:0] cent_mag(input atg_pkg::t_cent c);
        logic [14:0] q0;
        logic [27:0] r;
        logic [14:0] q;
        q0 = c.prod[54:40];
        r  = c.t - 28'(q0) * atg_pkg::DIV_10K;
        q  = (r >= atg_pkg::DIV_10K) ? (q0 + 15'd1) : q0;
        return (q > atg_pkg::ANGLE_MAX) ? atg_pkg::ANGLE_MAX : q;
    endfunction

    // magnitude pass
    logic            rmv [0:N];
    logic            pmv [0:N];
    atg_pkg::t_cword rmx [0:N];
    atg_pkg::t_cword rmy [0:N];
    atg_pkg::t_cword pmx [0:N];
    atg_pkg::t_cword pmy [0:N];
    atg_pkg::t_mside rms [0:N];
    logic [15:0]     pms [0:N];

    // angle pass
    logic            rav [0:N];
    logic            pav [0:N];
    atg_pkg::t_cword rax [0:N];
    atg_pkg::t_cword ray [0:N];
    atg_pkg::t_cword raz [0:N];
    atg_pkg::t_cword pax [0:N];
    atg_pkg::t_cword pay [0:N];
    atg_pkg::t_cword paz [0:N];
    atg_pkg::t_aside ras [0:N];
    logic            pas [0:N];

    // input capture
    logic            r_in_valid;
    atg_pkg::t_cword r_rx0, r_ry0, r_px0, r_py0;
    atg_pkg::t_mside r_rside0;
    logic [15:0]     r_pside0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
        r_rx0        <= to_q12(abs16(i_accel_z));
        r_ry0        <= atg_pkg::t_cword'(i_accel_x) <<< atg_pkg::FRAC_BITS;
        r_px0        <= to_q12(abs16(i_accel_z));
        r_py0        <= atg_pkg::t_cword'(i_accel_y) <<< atg_pkg::FRAC_BITS;
        r_rside0.num <= i_accel_y;
        r_rside0.gx  <= i_gyro_x;
        r_rside0.gy  <= i_gyro_y;
        r_rside0.gz  <= i_gyro_z;
        r_pside0     <= i_accel_x;
    end

    assign rmv[0] = r_in_valid;
    assign pmv[0] = r_in_valid;
    assign rmx[0] = r_rx0;
    assign rmy[0] = r_ry0;
    assign pmx[0] = r_px0;
    assign pmy[0] = r_py0;
    assign rms[0] = r_rside0;
    assign pms[0] = r_pside0;

    for (genvar i = 0; i < N; i++) begin : g_mag
        atg_cordic_stage #(.SHIFT(i), .SIDE_W($bits(atg_pkg::t_mside))) u_roll (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(rmv[i]),
            .i_x(rmx[i]), .i_y(rmy[i]), .i_z('0), .i_side(rms[i]),
            .o_valid(rmv[i+1]), .o_x(rmx[i+1]), .o_y(rmy[i+1]), .o_z(),
            .o_side(rms[i+1])
        );
        atg_cordic_stage #(.SHIFT(i), .SIDE_W(16)) u_pitch (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(pmv[i]),
            .i_x(pmx[i]), .i_y(pmy[i]), .i_z('0), .i_side(pms[i]),
            .o_valid(pmv[i+1]), .o_x(pmx[i+1]), .o_y(pmy[i+1]), .o_z(),
            .o_side(pms[i+1])
        );
    end

    // gain compensation
    logic               r_g_valid;
    atg_pkg::t_prod     r_rprod, r_pprod;
    logic signed [15:0] r_rnum, r_pnum;
    atg_pkg::t_grate    r_gx, r_gy, r_gz;
    atg_pkg::t_cword    rmag, pmag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
        end else begin
            r_g_valid <= rmv[N];
        end
        r_rprod <= rmx[N] * atg_pkg::INV_GAIN_Q30;
        r_pprod <= pmx[N] * atg_pkg::INV_GAIN_Q30;
        r_rnum  <= rms[N].num;
        r_pnum  <= pms[N];
        r_gx    <= gyro_pre(rms[N].gx);
        r_gy    <= gyro_pre(rms[N].gy);
        r_gz    <= gyro_pre(rms[N].gz);
    end

    assign rmag = r_rprod[atg_pkg::CW+29:30];
    assign pmag = r_pprod[atg_pkg::CW+29:30];

    assign rav[0]      = r_g_valid;
    assign pav[0]      = r_g_valid;
    assign rax[0]      = rmag;
    assign ray[0]      = atg_pkg::t_cword'(r_rnum) <<< atg_pkg::FRAC_BITS;
    assign raz[0]      = '0;
    assign pax[0]      = pmag;
    assign pay[0]      = atg_pkg::t_cword'(r_pnum) <<< atg_pkg::FRAC_BITS;
    assign paz[0]      = '0;
    assign ras[0].zero = (rmag == '0) && (r_rnum == '0);
    assign ras[0].gx   = r_gx;
    assign ras[0].gy   = r_gy;
    assign ras[0].gz   = r_gz;
    assign pas[0]      = (pmag == '0) && (r_pnum == '0);

    for (genvar i = 0; i < N; i++) begin : g_ang
        atg_cordic_stage #(.SHIFT(i), .SIDE_W($bits(atg_pkg::t_aside))) u_roll (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(rav[i]),
            .i_x(rax[i]), .i_y(ray[i]), .i_z(raz[i]), .i_side(ras[i]),
            .o_valid(rav[i+1]), .o_x(rax[i+1]), .o_y(ray[i+1]), .o_z(raz[i+1]),
            .o_side(ras[i+1])
        );
        atg_cordic_stage #(.SHIFT(i), .SIDE_W(1)) u_pitch (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(pav[i]),
            .i_x(pax[i]), .i_y(pay[i]), .i_z(paz[i]), .i_side(pas[i]),
            .o_valid(pav[i+1]), .o_x(pax[i+1]), .o_y(pay[i+1]), .o_z(paz[i+1]),
            .o_side(pas[i+1])
        );
    end

    // rounding divide, multiply half
    logic            r_d_valid;
    atg_pkg::t_cent  r_rc, r_pc;
    atg_pkg::t_gdiv  r_dx, r_dy, r_dz;
    atg_pkg::t_cword n_rz, n_pz;

    always_comb begin
        n_rz = ras[N].zero ? '0 : raz[N];
        n_pz = pas[N]      ? '0 : paz[N];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else begin
            r_d_valid <= rav[N];
        end
        r_rc <= cent_mul(n_rz);
        r_pc <= cent_mul(n_pz);
        r_dx <= gyro_mul(ras[N].gx);
        r_dy <= gyro_mul(ras[N].gy);
        r_dz <= gyro_mul(ras[N].gz);
    end

    // correction, sign and output register
    logic               r_done;
    logic signed [14:0] r_roll, r_pitch;
    logic signed [16:0] r_rate_x, r_rate_y, r_rate_z;
    logic [14:0]        n_rmag, n_pmag;

    always_comb begin
        n_rmag = cent_mag(r_rc);
        n_pmag = cent_mag(r_pc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_d_valid;
        end
        r_roll   <= r_rc.neg ? -$signed(n_rmag) : $signed(n_rmag);
        r_pitch  <= r_pc.neg ? $signed(n_pmag) : -$signed(n_pmag);
        r_rate_x <= gyro_fin(r_dx);
        r_rate_y <= gyro_fin(r_dy);
        r_rate_z <= gyro_fin(r_dz);
    end

    assign busy             = 1'b0;
    assign o_done           = r_done;
    assign o_roll_centideg  = r_roll;
    assign o_pitch_centideg = r_pitch;
    assign o_rate_x_cdps    = r_rate_x;
    assign o_rate_y_cdps    = r_rate_y;
    assign o_rate_z_cdps    = r_rate_z;

    `ATG_ASSERT(a_latency, i_clk, i_rst_n, (start && !busy) |-> ##(LAT) o_done, "result missing")
    `ATG_NEVER(a_lanes, i_clk, i_rst_n, rav[N] != pav[N], "roll and pitch lanes out of step")
    `ATG_ASSERT(a_range, i_clk, i_rst_n, o_done |-> (o_roll_centideg <= 15'sd9000 && o_roll_centideg >= -15'sd9000 && o_pitch_centideg <= 15'sd9000 && o_pitch_centideg >= -15'sd9000), "angle out of range")

endmodule

`default_nettype wire

// ===== tb/sv/accel_tilt_and_gyro_rate_top_tb.sv =====
// ----------------------------------------------------------------------------
// accel_tilt_and_gyro_rate_top_tb
// Drives six-axis samples into the tilt and gyro rate block and checks every
// result (roll, pitch, three rates) against an in-bench CORDIC predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_tilt_and_gyro_rate_top_tb;

    localparam int STAGES  = 16;
    localparam int LATENCY = 2 * STAGES + 4;

    typedef struct {
        logic signed [14:0] roll;
        logic signed [14:0] pitch;
        logic signed [16:0] rx;
        logic signed [16:0] ry;
        logic signed [16:0] rz;
    } t_tilt_rate;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic signed [15:0] i_accel_x = '0, i_accel_y = '0, i_accel_z = '0;
    logic signed [15:0] i_gyro_x = '0, i_gyro_y = '0, i_gyro_z = '0;
    wire                busy, o_done;
    wire signed [14:0]  o_roll_centideg, o_pitch_centideg;
    wire signed [16:0]  o_rate_x_cdps, o_rate_y_cdps, o_rate_z_cdps;

    int errors = 0;
    int idle_pct = 0;

    accel_tilt_and_gyro_rate_top #(.CORDIC_STAGES(STAGES)) dut (.*);

    always #1 i_clk = ~i_clk;

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint atan_tab(int i);
        longint t [24] = '{45000000, 26565051, 14036243, 7125016, 3576334, 1789911,
            895174, 447614, 223811, 111906, 55953, 27976, 13988, 6994, 3497, 1749,
            874, 437, 219, 109, 55, 27, 14, 7};
        return t[i];
    endfunction

    function automatic longint vec_mag(longint x, longint y);
        longint xs, ys;
        for (int i = 0; i < STAGES && i < 24; i++) begin
            xs = fshr(x, i);
            ys = fshr(y, i);
            if (y >= 0) begin
                x += ys; y -= xs;
            end else begin
                x -= ys; y += xs;
            end
        end
        return fshr(x * 64'sd652032874, 30);
    endfunction

    function automatic longint vec_angle(longint x, longint y);
        longint z, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        for (int i = 0; i < STAGES && i < 24; i++) begin
            xs = fshr(x, i);
            ys = fshr(y, i);
            if (y >= 0) begin
                x += ys; y -= xs; z += atan_tab(i);
            end else begin
                x -= ys; y += xs; z -= atan_tab(i);
            end
        end
        return z;
    endfunction

    function automatic longint udeg_to_centi(longint z);
        longint c;
        c = (z >= 0) ? (z + 5000) / 10000 : -((-z + 5000) / 10000);
        if (c > 9000) c = 9000;
        if (c < -9000) c = -9000;
        return c;
    endfunction

    function automatic longint tilt_udeg(longint num, longint a, longint b);
        longint aa;
        aa = (a < 0) ? -a : a;
        return vec_angle(vec_mag(aa * 4096, b * 4096), num * 4096);
    endfunction

    function automatic longint gyro_cdps(longint raw);
        longint n;
        n = raw * 200;
        return (n >= 0) ? (n + 65) / 131 : -((-n + 65) / 131);
    endfunction

    function automatic t_tilt_rate predict_sample(logic signed [15:0] ax, ay, az,
                                                  gx, gy, gz);
        t_tilt_rate r;
        r.roll  = 15'(udeg_to_centi(tilt_udeg(ay, az, ax)));
        r.pitch = 15'(udeg_to_centi(-tilt_udeg(ax, az, ay)));
        r.rx    = 17'(gyro_cdps(gx));
        r.ry    = 17'(gyro_cdps(gy));
        r.rz    = 17'(gyro_cdps(gz));
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    class tilt_scoreboard;
        t_tilt_rate pending[$];
        int checked = 0;

        function void note_sample(t_tilt_rate r);
            pending.push_back(r);
        endfunction

        task check_result(t_tilt_rate got);
            t_tilt_rate w;
            if (pending.size() == 0) begin
                report_mismatch("unexpected transaction", 0, 0);
                return;
            end
            w = pending.pop_front();
            checked++;
            if (got.roll !== w.roll) report_mismatch("roll", got.roll, w.roll);
            if (got.pitch !== w.pitch) report_mismatch("pitch", got.pitch, w.pitch);
            if (got.rx !== w.rx) report_mismatch("rate_x", got.rx, w.rx);
            if (got.ry !== w.ry) report_mismatch("rate_y", got.ry, w.ry);
            if (got.rz !== w.rz) report_mismatch("rate_z", got.rz, w.rz);
        endtask
    endclass

    tilt_scoreboard sb = new();

    always @(posedge i_clk) begin
        t_tilt_rate g;
        if (i_rst_n) begin
            if (start && !busy)
                sb.note_sample(predict_sample(i_accel_x, i_accel_y, i_accel_z,
                                              i_gyro_x, i_gyro_y, i_gyro_z));
            if (o_done) begin
                g.roll = o_roll_centideg;  g.pitch = o_pitch_centideg;
                g.rx = o_rate_x_cdps;      g.ry = o_rate_y_cdps;
                g.rz = o_rate_z_cdps;
                sb.check_result(g);
            end
        end
    end

    // one transaction; start stays high across back-to-back samples
    task automatic send_sample(logic signed [15:0] ax, ay, az, gx, gy, gz);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_accel_x <= ax; i_accel_y <= ay; i_accel_z <= az;
        i_gyro_x <= gx;  i_gyro_y <= gy;  i_gyro_z <= gz;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(5))
            0: return 16'(int'($urandom_range(64)) - 32);
            1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            2: return 16'(int'($urandom_range(8000)) - 4000);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] ext [4] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF};
        int wait_cycles;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // zero vector, vertical vectors, extremes, gyro rounding edges
        send_sample(0, 0, 0, 0, 0, 0);
        send_sample(0, 0, 16'sh7FFF, 1, -1, 131);
        send_sample(16'sh7FFF, 0, 0, -131, 16'sh7FFF, 16'sh8000);
        send_sample(0, 16'sh8000, 0, 65, -66, 66);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000, -32768, 32767, 0);
        send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 2, -2, 3);
        send_sample(1, -1, 0, 0, 0, 0);
        for (int i = 0; i < 16; i++)
            send_sample(ext[i % 4], ext[(i / 4) % 4], ext[(i + 1) % 4],
                        ext[i % 4], ext[(i + 2) % 4], ext[(i / 4) % 4]);
        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 37 : (ph == 1) ? 75 : 0;
            for (int n = 0; n < 420; n++)
                send_sample(rand_axis(), rand_axis(), rand_axis(),
                            16'($urandom), 16'($urandom), rand_axis());
        end
        start <= 1'b0;
        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 10 * LATENCY) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (LATENCY) @(posedge i_clk);
        if (sb.pending.size() != 0) report_mismatch("results outstanding",
                                                    sb.pending.size(), 0);
        $display("Checked %0d samples: directed extremes plus random under three idle mixes.",
                 sb.checked);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #200000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
